@@ rtl/core/gdad_pkg.sv @@
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared widths, constants and calendar helpers for the date-add block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdad_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned AddW   = 16;
  localparam int unsigned AccW   = 17;
  localparam int unsigned LenW   = 5;
  localparam int unsigned ModW   = 9;
  localparam int unsigned StepW  = 3;

  localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

  localparam logic [ModW-1:0] Cycle400    = ModW'(400);
  localparam logic [ModW-1:0] Cycle400Top = ModW'(399);
  localparam logic [ModW-1:0] Century1    = ModW'(100);
  localparam logic [ModW-1:0] Century2    = ModW'(200);
  localparam logic [ModW-1:0] Century3    = ModW'(300);
  localparam logic [StepW-1:0] ModSteps   = StepW'(5);

  // r is the year modulo 400
  function automatic logic is_leap(input logic [ModW-1:0] r);
    logic lp;
    lp = (r[1:0] == 2'b00) && (r != Century1) && (r != Century2) && (r != Century3);
    return lp;
  endfunction

  function automatic logic [LenW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [LenW-1:0] len;
    case (m)
      4'd2:    len = leap ? LenW'(29) : LenW'(28);
      4'd4:    len = LenW'(30);
      4'd6:    len = LenW'(30);
      4'd9:    len = LenW'(30);
      4'd11:   len = LenW'(30);
      default: len = LenW'(31);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/gregorian_date_add_days_top.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top
// Adds a day count to a Gregorian date by walking months with one adder.
//
// Input channel (in_valid_i/in_ready_o) carries a request: start year, month,
// day and a day count. Output channel (out_valid_o/out_ready_i) returns the
// resulting date, one result per request, in order.
// A request is taken only while the sequencer is idle. It then reduces the year
// modulo 400 (leap rule), sums the lengths of earlier months plus the count, and
// walks forward month by month. All steps share one 18-bit add/subtract unit.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the walk holds on its last step until the
// output register frees up.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// out_valid_o.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_add_days_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [gdad_pkg::YearW-1:0]    start_year_i,
  input  wire logic [gdad_pkg::MonthW-1:0]   start_month_i,
  input  wire logic [gdad_pkg::DayW-1:0]     start_day_i,
  input  wire logic [gdad_pkg::AddW-1:0]     add_days_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [gdad_pkg::YearW-1:0]    result_year_o,
  output      logic [gdad_pkg::MonthW-1:0]   result_month_o,
  output      logic [gdad_pkg::DayW-1:0]     result_day_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMod  = 2'd1;
  localparam logic [1:0] StSum  = 2'd2;
  localparam logic [1:0] StWalk = 2'd3;

  localparam int unsigned OpW = gdad_pkg::AccW + 1;

  logic [1:0]                    state_q, state_d;
  logic [gdad_pkg::YearW-1:0]    year_q, year_d;
  logic [gdad_pkg::YearW-1:0]    rmod_q, rmod_d;
  logic [gdad_pkg::MonthW-1:0]   smonth_q, smonth_d;
  logic [gdad_pkg::MonthW-1:0]   month_q, month_d;
  logic [gdad_pkg::AccW-1:0]     acc_q, acc_d;
  logic [gdad_pkg::AddW-1:0]     add_q, add_d;
  logic [gdad_pkg::StepW-1:0]    step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  logic [gdad_pkg::YearW-1:0]    ryear_q, ryear_d;
  logic [gdad_pkg::MonthW-1:0]   rmonth_q, rmonth_d;
  logic [gdad_pkg::DayW-1:0]     rday_q, rday_d;

  logic [OpW-1:0]                op_a, op_b, op_res;
  logic                          op_sub, borrow;
  logic                          leap;
  logic [gdad_pkg::LenW-1:0]     len;
  logic                          sum_more;
  logic                          out_free;
  logic [gdad_pkg::ModW-1:0]     rmod_lo;

  assign rmod_lo  = rmod_q[gdad_pkg::ModW-1:0];
  assign leap     = gdad_pkg::is_leap(rmod_lo);
  assign len      = gdad_pkg::month_len(month_q, leap);
  assign sum_more = (month_q < smonth_q) && (month_q <= gdad_pkg::MonthDec);
  assign out_free = !out_valid_q || out_ready_i;

  // shared add/subtract unit
  always_comb begin
    op_a   = OpW'(acc_q);
    op_b   = OpW'(len);
    op_sub = 1'b0;
    case (state_q)
      StMod: begin
        op_a   = OpW'(rmod_q);
        op_b   = OpW'(gdad_pkg::Cycle400) << step_q;
        op_sub = 1'b1;
      end
      StSum: begin
        op_b = sum_more ? OpW'(len) : OpW'(add_q);
      end
      StWalk: begin
        op_sub = 1'b1;
      end
      default: begin
        op_sub = 1'b0;
      end
    endcase
  end

  assign op_res = op_sub ? (op_a - op_b) : (op_a + op_b);
  assign borrow = op_res[OpW-1];

  always_comb begin
    state_d     = state_q;
    year_d      = year_q;
    rmod_d      = rmod_q;
    smonth_d    = smonth_q;
    month_d     = month_q;
    acc_d       = acc_q;
    add_d       = add_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ryear_d     = ryear_q;
    rmonth_d    = rmonth_q;
    rday_d      = rday_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          year_d   = start_year_i;
          rmod_d   = start_year_i;
          smonth_d = start_month_i;
          month_d  = gdad_pkg::MonthJan;
          acc_d    = gdad_pkg::AccW'(start_day_i);
          add_d    = add_days_i;
          step_d   = gdad_pkg::ModSteps;
          state_d  = StMod;
        end
      end
      StMod: begin
        if (!borrow) begin
          rmod_d = op_res[gdad_pkg::YearW-1:0];
        end
        step_d = step_q - gdad_pkg::StepW'(1);
        if (step_q == '0) begin
          state_d = StSum;
        end
      end
      StSum: begin
        acc_d = op_res[gdad_pkg::AccW-1:0];
        if (sum_more) begin
          month_d = month_q + gdad_pkg::MonthW'(1);
        end else begin
          month_d = gdad_pkg::MonthJan;
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (acc_q != '0 && !borrow && op_res != '0) begin
          acc_d = op_res[gdad_pkg::AccW-1:0];
          if (month_q == gdad_pkg::MonthDec) begin
            month_d = gdad_pkg::MonthJan;
            year_d  = year_q + gdad_pkg::YearW'(1);
            if (year_q == '1 || rmod_lo == gdad_pkg::Cycle400Top) begin
              rmod_d = '0;
            end else begin
              rmod_d = rmod_q + gdad_pkg::YearW'(1);
            end
          end else begin
            month_d = month_q + gdad_pkg::MonthW'(1);
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          ryear_d     = year_q;
          rmonth_d    = month_q;
          rday_d      = (acc_q == '0) ? gdad_pkg::DayW'(1) : acc_q[gdad_pkg::DayW-1:0];
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q   <= year_d;
    rmod_q   <= rmod_d;
    smonth_q <= smonth_d;
    month_q  <= month_d;
    acc_q    <= acc_d;
    add_q    <= add_d;
    step_q   <= step_d;
    ryear_q  <= ryear_d;
    rmonth_q <= rmonth_d;
    rday_q   <= rday_d;
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign result_year_o  = ryear_q;
  assign result_month_o = rmonth_q;
  assign result_day_o   = rday_q;

  a_rmod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSum || state_q == StWalk) |-> (rmod_q < gdad_pkg::YearW'(400)))
    else $error("year residue out of range");

  a_walk_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (month_q >= gdad_pkg::MonthJan && month_q <= gdad_pkg::MonthDec))
    else $error("walk month out of range");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StWalk))
    else $error("result loaded outside walk");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (rday_q != '0))
    else $error("result day is zero");

endmodule

`default_nettype wire
